[hdl/tsq_pkg.sv]
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [PTR_W-1:0]             ptr_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [VAL_W-1:0]      val_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_XFER,
    BK_POP
  } bk_state_t;

  typedef struct packed {
    op_t   op;
    data_t data;
  } req_t;

  typedef struct packed {
    status_t status;
    val_t    value;
    logic    now_empty;
  } rsp_t;

  // Sign-extend a stored element to the result width (or cut it down).
  function automatic val_t widen(data_t d);
    return val_t'(d);
  endfunction

endpackage

[hdl/tsq_if.sv]
`timescale 1ns / 1ps

interface tsq_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface tsq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_value;
  logic               now_empty;

  modport source (output valid, output status, output out_value, output now_empty,
                  input ready);
  modport sink   (input valid, input status, input out_value, input now_empty,
                  output ready);
endinterface

[hdl/tsq_front.sv]
`timescale 1ns / 1ps

module tsq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_cmd,
  input  logic signed [31:0] in_value,
  output logic          push,
  output tsq_pkg::req_t push_data,
  input  logic          q_full
);

  logic          vld_r, vld_nxt;
  tsq_pkg::req_t req_r, req_nxt;

  always_comb begin
    push     = vld_r && !q_full;
    in_ready = !vld_r || push;
    vld_nxt  = vld_r && !push;
    req_nxt  = req_r;
    if (in_valid && in_ready) begin
      vld_nxt      = 1'b1;
      req_nxt.op   = tsq_pkg::op_t'(in_cmd);
      // keep the low element bits only
      req_nxt.data = tsq_pkg::data_t'(in_value);
    end
  end

  assign push_data = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    req_r <= req_nxt;
  end

endmodule

[hdl/tsq_req_fifo.sv]
`timescale 1ns / 1ps

module tsq_req_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsq_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output tsq_pkg::req_t pop_data,
  output logic          empty
);

  tsq_pkg::req_t                      mem [tsq_pkg::QUEUE_DEPTH];
  logic [tsq_pkg::QPTR_W-1:0]         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [tsq_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               do_push, do_pop;

  assign full     = (cnt_r == tsq_pkg::QCNT_W'(tsq_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == tsq_pkg::QPTR_W'(tsq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == tsq_pkg::QPTR_W'(tsq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem[wp_r] <= push_data;
    end
  end

endmodule

[hdl/tsq_back.sv]
`timescale 1ns / 1ps

module tsq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tsq_pkg::req_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output tsq_pkg::rsp_t out_rsp
);

  tsq_pkg::data_t in_mem  [tsq_pkg::STACK_DEPTH];
  tsq_pkg::data_t out_mem [tsq_pkg::STACK_DEPTH];

  tsq_pkg::bk_state_t state_r, state_nxt;
  tsq_pkg::cnt_t      in_cnt_r, in_cnt_nxt, out_cnt_r, out_cnt_nxt;
  tsq_pkg::req_t      req_r, req_nxt;
  logic               xv_r, xv_nxt;
  logic               out_vld_r, out_vld_nxt;
  tsq_pkg::rsp_t      rsp_r, rsp_nxt;

  logic               in_we, in_re, out_we, out_re;
  tsq_pkg::ptr_t      in_wa, in_ra, out_wa, out_ra;
  tsq_pkg::data_t     in_wd, out_wd;
  tsq_pkg::data_t     in_rd_r, out_rd_r;
  logic               out_free;

  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    state_nxt   = state_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    req_nxt     = req_r;
    xv_nxt      = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;
    rsp_nxt     = rsp_r;
    q_pop       = 1'b0;
    in_we       = 1'b0;
    in_re       = 1'b0;
    out_we      = 1'b0;
    out_re      = 1'b0;
    in_wa       = tsq_pkg::ptr_t'(in_cnt_r);
    in_ra       = tsq_pkg::ptr_t'(in_cnt_r - tsq_pkg::cnt_t'(1));
    out_wa      = tsq_pkg::ptr_t'(out_cnt_r);
    out_ra      = tsq_pkg::ptr_t'(out_cnt_r - tsq_pkg::cnt_t'(1));
    in_wd       = q_data.data;
    out_wd      = in_rd_r;

    case (state_r)
      tsq_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop   = 1'b1;
          req_nxt = q_data;
          case (q_data.op)
            tsq_pkg::OP_ENQ: begin
              if (in_cnt_r == tsq_pkg::cnt_t'(tsq_pkg::STACK_DEPTH)) begin
                if (out_cnt_r != '0) begin
                  out_vld_nxt = 1'b1;
                  rsp_nxt     = '{tsq_pkg::STAT_FULL, '0, 1'b0};
                end else begin
                  state_nxt = tsq_pkg::BK_XFER;
                end
              end else begin
                in_we       = 1'b1;
                in_cnt_nxt  = in_cnt_r + tsq_pkg::cnt_t'(1);
                out_vld_nxt = 1'b1;
                rsp_nxt     = '{tsq_pkg::STAT_DONE, '0, 1'b0};
              end
            end
            tsq_pkg::OP_DEQ: begin
              if (out_cnt_r == '0) begin
                if (in_cnt_r == '0) begin
                  out_vld_nxt = 1'b1;
                  rsp_nxt     = '{tsq_pkg::STAT_EMPTY, '0, 1'b1};
                end else begin
                  state_nxt = tsq_pkg::BK_XFER;
                end
              end else begin
                out_re      = 1'b1;
                out_cnt_nxt = out_cnt_r - tsq_pkg::cnt_t'(1);
                state_nxt   = tsq_pkg::BK_POP;
              end
            end
            default: ;
          endcase
        end
      end

      tsq_pkg::BK_XFER: begin
        // drain the input stack top-first onto the output stack, one per cycle
        if (xv_r) begin
          out_we      = 1'b1;
          out_cnt_nxt = out_cnt_r + tsq_pkg::cnt_t'(1);
        end
        if (in_cnt_r != '0) begin
          in_re      = 1'b1;
          in_cnt_nxt = in_cnt_r - tsq_pkg::cnt_t'(1);
          xv_nxt     = 1'b1;
        end else if (!xv_r) begin
          if (req_r.op == tsq_pkg::OP_ENQ) begin
            in_we       = 1'b1;
            in_wd       = req_r.data;
            in_cnt_nxt  = tsq_pkg::cnt_t'(1);
            out_vld_nxt = 1'b1;
            rsp_nxt     = '{tsq_pkg::STAT_DONE, '0, 1'b0};
            state_nxt   = tsq_pkg::BK_IDLE;
          end else begin
            out_re      = 1'b1;
            out_cnt_nxt = out_cnt_r - tsq_pkg::cnt_t'(1);
            state_nxt   = tsq_pkg::BK_POP;
          end
        end
      end

      tsq_pkg::BK_POP: begin
        out_vld_nxt = 1'b1;
        rsp_nxt     = '{tsq_pkg::STAT_DONE, tsq_pkg::widen(out_rd_r),
                        (in_cnt_r == '0) && (out_cnt_r == '0)};
        state_nxt   = tsq_pkg::BK_IDLE;
      end

      default: begin
        state_nxt = tsq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tsq_pkg::BK_IDLE;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      xv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      xv_r      <= xv_nxt;
      out_vld_r <= out_vld_nxt;
    end
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[in_wa] <= in_wd;
    end
    if (in_re) begin
      in_rd_r <= in_mem[in_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_wa] <= out_wd;
    end
    if (out_re) begin
      out_rd_r <= out_mem[out_ra];
    end
  end

endmodule

[hdl/two_stack_queue_unit.sv]
`timescale 1ns / 1ps

// FIFO queue built from two 32-entry stacks, one request in, one response out per item.
// cmd 0 enqueues value, cmd 1 dequeues the oldest element; status reports done, full
// (input stack full while the output stack still holds data) or empty, and now_empty
// flags that both stacks are empty after the request. An item passes a one-entry input
// register and a two-entry request queue; the back end answers a plain enqueue or a refused
// request from its idle state, and a dequeue from the output stack after a RAM read. When
// the output stack must be refilled, the back end first moves the input stack over one
// element per cycle through the stack RAM read ports, then finishes the enqueue or dequeue.
// Responses wait in an output register, so the front keeps taking requests while one is
// unread, until the input register and request queue are full.
module two_stack_queue_unit (
  input logic   clk,
  input logic   rst_n,
  tsq_in_if.sink    in_ch,
  tsq_out_if.source out_ch
);

  logic          push, q_full, q_pop, q_empty;
  tsq_pkg::req_t push_data, q_data;
  logic          rsp_valid;
  tsq_pkg::rsp_t rsp;

  // Register and decode incoming requests.
  tsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_value  (in_ch.value),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Hold decoded requests while the back end is busy moving a stack or a response is unread.
  tsq_req_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Stacks, transfer sequencer and response register.
  tsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (rsp_valid),
    .out_ready (out_ch.ready),
    .out_rsp   (rsp)
  );

  // Drive the response channel from the registered response.
  assign out_ch.valid     = rsp_valid;
  assign out_ch.status    = rsp.status;
  assign out_ch.out_value = rsp.value;
  assign out_ch.now_empty = rsp.now_empty;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tsq_pkg::*;

  localparam int RAND_ITEMS  = 1200;
  localparam int TAIL_ITEMS  = 150;     // final stretch with no idling on either side
  localparam int SETTLE_CYC  = 40;      // quiet window to catch any stray extra response
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_MAX   = 30;

  typedef struct {
    op_t  op;
    val_t value;
    bit   hold;     // wait for every outstanding result before presenting
  } req_item_t;

  logic clk = 1'b0;
  logic rst_n;

  tsq_in_if  in_if();
  tsq_out_if out_if();

  two_stack_queue_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always #5 clk = ~clk;

  // Hold reset low at the start, then release it for good.
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Keep every input known before the first edge.
  initial begin
    in_if.valid  = 1'b0;
    in_if.cmd    = OP_ENQ;
    in_if.value  = '0;
    out_if.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue predictor: its own pair of stacks and counts.
  // ---------------------------------------------------------------------------
  data_t     in_stk  [STACK_DEPTH];
  data_t     out_stk [STACK_DEPTH];
  int        in_cnt;
  int        out_cnt;
  rsp_t      rsp_expected[$];
  req_item_t req_pending[$];

  int n_enq_done, n_enq_full, n_deq_done, n_deq_empty, n_refills;
  int n_results, n_errors;

  // Move the whole input stack onto the (empty) output stack, reversing it.
  task automatic stack_transfer();
    n_refills++;
    while (in_cnt > 0 && out_cnt < STACK_DEPTH) begin
      in_cnt--;
      out_stk[out_cnt] = in_stk[in_cnt];
      out_cnt++;
    end
  endtask

  // Apply one accepted request and queue the response it must produce.
  task automatic queue_predict(input op_t op, input val_t v);
    rsp_t    r;
    status_t st;
    val_t    res;
    st  = STAT_DONE;
    res = '0;
    if (op == OP_ENQ) begin
      if (in_cnt >= STACK_DEPTH) begin
        // input stack full: refill only if the output stack is drained
        if (out_cnt != 0) st = STAT_FULL;
        else stack_transfer();
      end
      if (st == STAT_DONE && in_cnt < STACK_DEPTH) begin
        in_stk[in_cnt] = data_t'(v);
        in_cnt++;
      end
      if (st == STAT_DONE) n_enq_done++;
      else n_enq_full++;
    end else begin
      if (out_cnt == 0) begin
        if (in_cnt == 0) st = STAT_EMPTY;
        else stack_transfer();
      end
      if (st == STAT_DONE && out_cnt > 0) begin
        out_cnt--;
        res = val_t'(out_stk[out_cnt]);
      end
      if (st == STAT_DONE) n_deq_done++;
      else n_deq_empty++;
    end
    r.status    = st;
    r.value     = res;
    r.now_empty = (in_cnt == 0 && out_cnt == 0);
    rsp_expected.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < PRINT_MAX)
      $display("[%0t] result %0d: %s got %h, expected %h", $realtime, n_results, what,
               got, want);
    n_errors++;
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 11))
      0:       return val_t'(32'h7fff_ffff);
      1:       return val_t'(32'h8000_0000);
      2:       return '0;
      3:       return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic add_req(input op_t op, input val_t v, input bit hold);
    req_item_t it;
    it.op    = op;
    it.value = v;
    it.hold  = hold;
    req_pending.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: present pending items, predict on acceptance.
  // ---------------------------------------------------------------------------
  int   in_gap;
  int   in_flight;      // accepted requests whose response has not been taken
  logic calm;           // tail of the run: no idling anywhere
  logic nxt_valid;
  req_item_t nxt_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.cmd   <= OP_ENQ;
      in_if.value <= '0;
      calm        <= 1'b0;
      in_gap      = 0;
      in_flight   = 0;
    end else begin
      nxt_valid = in_if.valid;
      if (out_if.valid && out_if.ready) in_flight--;
      if (in_if.valid && in_if.ready) begin
        queue_predict(op_t'(in_if.cmd), in_if.value);
        in_flight++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (req_pending.size() > 0 &&
                     !(req_pending[0].hold && in_flight != 0)) begin
          // start an idle burst now and then, except in the calm tail
          if (req_pending.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 16);
          end else begin
            nxt_item = req_pending.pop_front();
            in_if.cmd   <= nxt_item.op;
            in_if.value <= nxt_item.value;
            nxt_valid   = 1'b1;
          end
        end
      end
      in_if.valid <= nxt_valid;
      calm        <= (req_pending.size() <= TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: stall at random, check each taken item against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  int   out_gap;
  logic nxt_ready;
  rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap      = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch("response with nothing expected", out_if.out_value, '0);
        end else begin
          want = rsp_expected.pop_front();
          if (out_if.status !== want.status)
            report_mismatch("status", 32'(out_if.status), 32'(want.status));
          if (out_if.out_value !== want.value)
            report_mismatch("out_value", out_if.out_value, want.value);
          if (out_if.now_empty !== want.now_empty)
            report_mismatch("now_empty", 32'(out_if.now_empty), 32'(want.now_empty));
        end
        n_results++;
      end
      if (out_gap > 0) begin
        out_gap--;
        nxt_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap   = $urandom_range(0, 16);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_if.ready <= nxt_ready;
    end
  end

  // Stop a hung run.
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               rsp_expected.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int seg;
    int len;
    int pct;
    int n_rand;
    in_cnt  = 0;
    out_cnt = 0;

    // Directed: empty dequeue, value extremes, order through one refill,
    // interleaving that refills while the input stack keeps growing.
    add_req(OP_DEQ, pick_value(), 1'b0);
    add_req(OP_ENQ, val_t'(32'h7fff_ffff), 1'b0);
    add_req(OP_ENQ, val_t'(32'h8000_0000), 1'b0);
    add_req(OP_ENQ, '0, 1'b0);
    add_req(OP_ENQ, '1, 1'b0);
    add_req(OP_ENQ, val_t'(32'h5555_5555), 1'b0);
    add_req(OP_ENQ, val_t'(32'haaaa_aaaa), 1'b0);
    repeat (6) add_req(OP_DEQ, '0, 1'b0);
    add_req(OP_DEQ, '1, 1'b0);
    add_req(OP_ENQ, val_t'(1), 1'b0);
    add_req(OP_DEQ, pick_value(), 1'b0);
    add_req(OP_ENQ, val_t'(2), 1'b0);
    add_req(OP_ENQ, val_t'(3), 1'b0);
    add_req(OP_DEQ, pick_value(), 1'b0);
    add_req(OP_ENQ, val_t'(4), 1'b0);
    repeat (3) add_req(OP_DEQ, pick_value(), 1'b0);

    // Random: segments leaning toward filling, draining or neither. The first
    // one leans hard toward filling so full refusals show up early.
    seg    = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      len = (seg == 0) ? 80 : $urandom_range(20, 80);
      case ((seg == 0) ? 0 : $urandom_range(0, 2))
        0:       pct = 85;
        1:       pct = 15;
        default: pct = 50;
      endcase
      for (int k = 0; k < len; k++)
        add_req(($urandom_range(0, 99) < pct) ? OP_ENQ : OP_DEQ, pick_value(),
                k == 0 && (seg == 3 || $urandom_range(0, 3) == 0));
      n_rand += len;
      seg++;
    end

    // Drain: everything sent, everything answered, then a quiet settle window
    // to catch any stray extra response.
    wait (rst_n === 1'b1);
    while (req_pending.size() != 0 || in_if.valid) @(posedge clk);
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("covered %0d responses: %0d enqueues, %0d refused full, %0d dequeues,",
             n_results, n_enq_done, n_enq_full, n_deq_done);
    $display("  %0d refused empty, %0d stack refills; %0d mismatches",
             n_deq_empty, n_refills, n_errors);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tsq_pkg.sv
hdl/tsq_if.sv
hdl/tsq_front.sv
hdl/tsq_req_fifo.sv
hdl/tsq_back.sv
hdl/two_stack_queue_unit.sv
bench/tb.sv
